// ===== design/bbc_pkg.sv =====
// Shared types and constants for the bounding box coalescer.
// No dependencies; imported by every module of the block except bbc_ram.
`default_nettype none

package bbc_pkg;

  // Capacity of the box list
  localparam int MAX_BOXES = 16;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int COUNT_W   = $clog2(MAX_BOXES + 1);

  // Fixed result field widths
  localparam int ENTRY_INDEX_W = 4;
  localparam int ENTRY_COUNT_W = 5;
  localparam int COORD_W       = 32;
  localparam int BOX_W         = 6 * COORD_W;

  // Stream widths
  localparam int S_DATA_W  = BOX_W;
  localparam int M_FIELD_W = ENTRY_INDEX_W + ENTRY_COUNT_W + BOX_W;
  localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_DATA_W - M_FIELD_W;

  // Box corners, lo_x in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] hi_z;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_x;
  } box_t;

  typedef enum logic [1:0] {
    ST_MERGED   = 2'd0,
    ST_APPENDED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_MISS,
    S_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // latch input item, clear list on start flag
    logic rd_en;     // read entry at scan index
    logic idx_inc;   // advance scan index
    logic merge;     // write union back at scan index
    logic miss;      // append or drop
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;  // scan index reached held count
    logic hit;       // entry read last cycle overlaps input box
    logic out_free;  // output register can take a result
  } stat_t;

endpackage

`default_nettype wire

// ===== design/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/bbc_ctrl.sv =====
// Controller state machine for the bounding box coalescer.
// Depends on bbc_pkg for the state, command and status types.
`default_nettype none

module bbc_ctrl
  import bbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  input  wire stat_t stat,
  output logic       s_tready,
  output cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_next = S_MISS;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.hit) begin
          cmd.merge  = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_MISS: begin
        cmd.miss   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bbc_datapath.sv =====
// Datapath for the bounding box coalescer: box list RAM, scan index,
// overlap test, union and output register. Depends on bbc_pkg and bbc_ram.
`default_nettype none

module bbc_datapath
  import bbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic                s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,
  output logic [1:0]               m_tuser
);

  // Input item and scan state
  box_t               in_box;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] idx;

  // Result and output registers
  status_t                  res_status;
  logic [ENTRY_INDEX_W-1:0] res_index;
  box_t                     res_box;
  status_t                  out_status;
  logic [ENTRY_INDEX_W-1:0] out_index;
  logic [ENTRY_COUNT_W-1:0] out_count;
  box_t                     out_box;

  // RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  box_t             ram_wdata;
  box_t             entry;
  logic [BOX_W-1:0] ram_rdata;

  logic full;
  logic overlap;
  box_t union_box;

  bbc_ram #(
    .WIDTH(BOX_W),
    .DEPTH(MAX_BOXES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign entry = box_t'(ram_rdata);
  assign full  = (count == COUNT_W'(MAX_BOXES));

  // Overlap or touch on all three axes
  assign overlap = !(($signed(in_box.hi_x) < $signed(entry.lo_x)) ||
                     ($signed(in_box.hi_y) < $signed(entry.lo_y)) ||
                     ($signed(in_box.hi_z) < $signed(entry.lo_z)) ||
                     ($signed(in_box.lo_x) > $signed(entry.hi_x)) ||
                     ($signed(in_box.lo_y) > $signed(entry.hi_y)) ||
                     ($signed(in_box.lo_z) > $signed(entry.hi_z)));

  always_comb begin
    union_box.lo_x = ($signed(in_box.lo_x) < $signed(entry.lo_x)) ? in_box.lo_x : entry.lo_x;
    union_box.lo_y = ($signed(in_box.lo_y) < $signed(entry.lo_y)) ? in_box.lo_y : entry.lo_y;
    union_box.lo_z = ($signed(in_box.lo_z) < $signed(entry.lo_z)) ? in_box.lo_z : entry.lo_z;
    union_box.hi_x = ($signed(in_box.hi_x) > $signed(entry.hi_x)) ? in_box.hi_x : entry.hi_x;
    union_box.hi_y = ($signed(in_box.hi_y) > $signed(entry.hi_y)) ? in_box.hi_y : entry.hi_y;
    union_box.hi_z = ($signed(in_box.hi_z) > $signed(entry.hi_z)) ? in_box.hi_z : entry.hi_z;
  end

  always_comb begin
    ram_we    = cmd.merge || (cmd.miss && !full);
    ram_waddr = cmd.merge ? idx[IDX_W-1:0] : count[IDX_W-1:0];
    ram_wdata = cmd.merge ? union_box : in_box;
  end

  always_comb begin
    stat.scan_end = (idx == count);
    stat.hit      = overlap;
    stat.out_free = !m_tvalid || m_tready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.load_in) begin
        idx <= '0;
        if (s_tuser) begin
          count <= '0;
        end
      end else if (cmd.idx_inc) begin
        idx <= idx + COUNT_W'(1);
      end
      if (cmd.miss && !full) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_box <= box_t'(s_tdata);
    end
    if (cmd.merge) begin
      res_status <= ST_MERGED;
      res_index  <= ENTRY_INDEX_W'(idx);
      res_box    <= union_box;
    end else if (cmd.miss) begin
      res_box <= in_box;
      if (full) begin
        res_status <= ST_DROPPED;
        res_index  <= '0;
      end else begin
        res_status <= ST_APPENDED;
        res_index  <= ENTRY_INDEX_W'(count);
      end
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_count  <= ENTRY_COUNT_W'(count);
      out_box    <= res_box;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_box, out_count, out_index};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== design/bounding_box_coalescer_unit.sv =====
// Top level of the bounding box coalescer: controller plus datapath.
// Depends on bbc_pkg, bbc_ctrl, bbc_datapath (and bbc_ram below it).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tdata box corners, s_tuser start
//  m       | out | m_tvalid/m_tready  | m_tdata index/count/box, m_tuser status
//
// Per item: the accept step (S_IDLE), then a read (S_SCAN) and a compare
// (S_CMP) for each list entry examined; on a miss S_SCAN sees the end of
// the list and S_MISS appends or drops; S_DONE hands the result to the
// output register once it is free. The service time is set by the single
// read port of the box RAM and its registered read data.
// Reset clears the held count, the controller and the output valid; the list
// RAM is not cleared, only entries below the count are ever read.
// A stalled output holds its item; the next item is taken while it waits.
`default_nettype none

module bounding_box_coalescer_unit
  import bbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (32 bits each, signed)
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // start_new
  input  wire logic                s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // entry_index[3:0], entry_count[8:4], out_lo_x, out_lo_y, out_lo_z,
  // out_hi_x, out_hi_y, out_hi_z (32 bits each, signed), zero pad
  output logic [M_DATA_W-1:0]      m_tdata,
  // status
  output logic [1:0]               m_tuser
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence accept, scan, merge or append, and result handoff
  bbc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .stat    (stat),
    .s_tready(s_tready),
    .cmd     (cmd)
  );

  // Hold the list, run the overlap test and union, drive the output
  bbc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // A result never overwrites one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending output item");

  // Only one item is in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in work");

  // A merge only follows a read of an entry that overlaps
  a_merge_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> ($past(cmd.rd_en) && stat.hit))
    else $error("merge without a preceding overlapping read");

  // Output valid rises only after a result load
  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("output valid without a result load");

endmodule

`default_nettype wire

// ===== verif/bounding_box_coalescer_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounding_box_coalescer_unit: a directed table, then random frames.
// Depends on bbc_pkg and the block under test. A built-in model of the box list predicts
// each result, and the result stream is compared item by item.

module bounding_box_coalescer_unit_test
  import bbc_pkg::*;
();

  localparam int RANDOM_ITEMS = 900;
  localparam int TAIL_CYCLES  = 40;  // margin beyond the longest service time
  localparam int SHOW_LIMIT   = 10;

  // One result item as it leaves the block
  typedef struct {
    status_t                  status;
    logic [ENTRY_INDEX_W-1:0] index;
    logic [ENTRY_COUNT_W-1:0] count;
    box_t                     box;
  } box_result_t;

  // One row of the directed table; the expected result is only used when it is typed in
  typedef struct {
    logic        start;
    box_t        box;
    bit          typed;
    box_result_t want;
  } box_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;

  // Shadow copy of the box list
  box_t        held_boxes [MAX_BOXES];
  int          held_num = 0;

  box_result_t pending_results [$];
  box_row_t    box_table [$];
  int          mismatches = 0;
  bit          send_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int          sink_hold = 0;

  always #2 clk = ~clk;

  bounding_box_coalescer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Predict the result of one box and update the shadow list. Scan in list order; the first
  // entry that overlaps or touches on all three axes absorbs the box, and the scan stops.
  function automatic box_result_t coalesce_box(input logic start, input box_t b);
    box_result_t r;
    bit          found;
    int          k;
    r.status = ST_DROPPED;
    r.index  = '0;
    r.box    = b;
    found    = 1'b0;
    if (start)
      held_num = 0;
    for (k = 0; k < held_num && !found; k++) begin
      if (!(b.hi_x < held_boxes[k].lo_x || b.hi_y < held_boxes[k].lo_y ||
            b.hi_z < held_boxes[k].lo_z || b.lo_x > held_boxes[k].hi_x ||
            b.lo_y > held_boxes[k].hi_y || b.lo_z > held_boxes[k].hi_z)) begin
        // Grow the entry to the union; inverted boxes are taken as given
        if (b.lo_x < held_boxes[k].lo_x) held_boxes[k].lo_x = b.lo_x;
        if (b.lo_y < held_boxes[k].lo_y) held_boxes[k].lo_y = b.lo_y;
        if (b.lo_z < held_boxes[k].lo_z) held_boxes[k].lo_z = b.lo_z;
        if (b.hi_x > held_boxes[k].hi_x) held_boxes[k].hi_x = b.hi_x;
        if (b.hi_y > held_boxes[k].hi_y) held_boxes[k].hi_y = b.hi_y;
        if (b.hi_z > held_boxes[k].hi_z) held_boxes[k].hi_z = b.hi_z;
        r.status = ST_MERGED;
        r.index  = k[ENTRY_INDEX_W-1:0];
        r.box    = held_boxes[k];
        found    = 1'b1;
      end
    end
    // Append on a miss while there is room; otherwise drop and echo the input
    if (!found && held_num < MAX_BOXES) begin
      held_boxes[held_num] = b;
      r.status = ST_APPENDED;
      r.index  = held_num[ENTRY_INDEX_W-1:0];
      r.box    = b;
      held_num++;
    end
    r.count = held_num[ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  function automatic box_t mk_box(input int lx, input int ly, input int lz,
                                  input int hx, input int hy, input int hz);
    box_t b;
    b.lo_x = lx; b.lo_y = ly; b.lo_z = lz;
    b.hi_x = hx; b.hi_y = hy; b.hi_z = hz;
    return b;
  endfunction

  // Add a table row; pass typed = 1 with a filled-in expectation to pin the result
  function automatic void add_row(input logic start, input box_t b, input bit typed = 1'b0,
                                  input status_t st = ST_MERGED, input int idx = 0,
                                  input int cnt = 0, input box_t rb = '0);
    box_row_t row;
    row.start        = start;
    row.box          = b;
    row.typed        = typed;
    row.want.status  = st;
    row.want.index   = idx[ENTRY_INDEX_W-1:0];
    row.want.count   = cnt[ENTRY_COUNT_W-1:0];
    row.want.box     = rb;
    box_table = {box_table, row};
  endfunction

  // Random box: each corner offset from a frame center, sometimes inverted, sometimes pure noise
  function automatic box_t rand_box(input int center, input int spread, input int size);
    box_t                      b;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic signed [COORD_W-1:0] tmp;
    int                        a;
    if ($urandom_range(0, 99) < 10) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return b;
    end
    for (a = 0; a < 3; a++) begin
      lo[a] = center + int'($urandom_range(0, spread));
      hi[a] = lo[a] + int'($urandom_range(0, size));
      if ($urandom_range(0, 99) < 5) begin
        tmp = lo[a]; lo[a] = hi[a]; hi[a] = tmp;
      end
    end
    b.lo_x = lo[0]; b.lo_y = lo[1]; b.lo_z = lo[2];
    b.hi_x = hi[0]; b.hi_y = hi[1]; b.hi_z = hi[2];
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 79) == 0)
      send_calm = !send_calm;
    if (send_calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Present one box, hold it until accepted, then queue its expected result.
  // Called at a rising edge; a zero gap keeps tvalid high into the next item.
  task automatic send_box(input logic start, input box_t b, input bit typed = 1'b0,
                          input box_result_t want = '{status: ST_MERGED, index: '0,
                                                      count: '0, box: '0});
    box_result_t r;
    int          gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = coalesce_box(start, b);
    if (!typed)
      want = r;
    pending_results = {pending_results, want};
  endtask

  // Receiver: stall at random, check each accepted result against the oldest expectation
  always @(posedge clk) begin
    box_result_t got;
    box_result_t want;
    if (m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.index  = m_tdata[ENTRY_INDEX_W-1:0];
      got.count  = m_tdata[ENTRY_INDEX_W +: ENTRY_COUNT_W];
      got.box    = m_tdata[ENTRY_INDEX_W + ENTRY_COUNT_W +: BOX_W];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t unexpected result: status %0d index %0d count %0d box %h",
                   $realtime, got.status, got.index, got.count, got.box);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.index !== want.index ||
            got.count !== want.count || got.box.lo_x !== want.box.lo_x ||
            got.box.lo_y !== want.box.lo_y || got.box.lo_z !== want.box.lo_z ||
            got.box.hi_x !== want.box.hi_x || got.box.hi_y !== want.box.hi_y ||
            got.box.hi_z !== want.box.hi_z) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT) begin
            $display("%0t mismatch: expected status %0d index %0d count %0d box %h",
                     $realtime, want.status, want.index, want.count, want.box);
            $display("%0t           actual status %0d index %0d count %0d box %h",
                     $realtime, got.status, got.index, got.count, got.box);
          end
        end
      end
    end
    // Drive ready for the next edge: stretches of steady ready, short and long stalls
    if ($urandom_range(0, 149) == 0)
      sink_calm = !sink_calm;
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 99) < 15)
        sink_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 30);
    end
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("bounding_box_coalescer_unit_test: FAIL");
    $finish;
  end

  initial begin
    box_t        full_box;
    box_t        b;
    int          k;
    int          sent;
    int          frame_len;
    int          center;
    int          spread;
    int          size;

    full_box = mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // Directed table. Right after reset the list is empty, so the widest box lands at entry 0.
    add_row(1'b0, full_box, 1'b1, ST_APPENDED, 0, 1, full_box);
    // Anything overlaps the widest box, and the union is the widest box again
    add_row(1'b0, mk_box(0, 0, 0, 1, 1, 1), 1'b1, ST_MERGED, 0, 1, full_box);
    // Start flag empties the list
    add_row(1'b1, mk_box(0, 0, 0, 10, 10, 10), 1'b1, ST_APPENDED, 0, 1,
            mk_box(0, 0, 0, 10, 10, 10));
    // Touching on the upper x face, then on the lower x face: both merge
    add_row(1'b0, mk_box(10, 0, 0, 20, 10, 10));
    add_row(1'b0, mk_box(-5, 0, 0, 0, 10, 10));
    // One step past the upper x face: append
    add_row(1'b0, mk_box(21, 0, 0, 30, 10, 10));
    // Entirely below the lower x bound: append (the x lower bound must be tested)
    add_row(1'b0, mk_box(-100, 0, 0, -6, 10, 10));
    // Inverted box, used as given
    add_row(1'b0, mk_box(5, 5, 5, 3, 3, 3));
    // Fill the list with disjoint boxes; the last two are apart only in y and only in z
    for (k = 1; k <= 11; k++)
      add_row(1'b0, mk_box(1000 * k, 0, 0, 1000 * k + 10, 10, 10));
    add_row(1'b0, mk_box(0, 500, 0, 10, 510, 10));
    add_row(1'b0, mk_box(0, 0, -600, 10, 10, -500));
    // List full: drop and echo the input
    b = mk_box(100000, 0, 0, 100010, 10, 10);
    add_row(1'b0, b, 1'b1, ST_DROPPED, 0, MAX_BOXES, b);
    // Start flag with a full list: empty first, then append at entry 0
    add_row(1'b1, b, 1'b1, ST_APPENDED, 0, 1, b);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (box_table[i])
      send_box(box_table[i].start, box_table[i].box, box_table[i].typed, box_table[i].want);

    // Random frames: dense frames merge a lot, sparse ones fill the list and drop
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 20);
      center    = $urandom;
      if ($urandom_range(0, 1)) begin
        spread = 1 << 12;
        size   = 1 << 10;
      end else begin
        spread = 32'h7FFF_FFFF;
        size   = 1 << 16;
      end
      for (k = 0; k < frame_len && sent < RANDOM_ITEMS; k++) begin
        send_box(k == 0 && $urandom_range(0, 4) != 0, rand_box(center, spread, size));
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then allow one full service time for stray results
    while (pending_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("bounding_box_coalescer_unit_test: PASS");
    else
      $display("bounding_box_coalescer_unit_test: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bbc_pkg.sv
design/bbc_ram.sv
design/bbc_ctrl.sv
design/bbc_datapath.sv
design/bounding_box_coalescer_unit.sv
verif/bounding_box_coalescer_unit_test.sv
